>>> rtl/stepper_trapezoid_profile_core_assert.svh
// Assertion macros used by the checker file.
`ifndef STEPPER_TRAPEZOID_PROFILE_CORE_ASSERT_SVH
`define STEPPER_TRAPEZOID_PROFILE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/stp_pkg.sv
`timescale 1ns / 1ps
package stp_pkg;

    localparam int MS_W       = 16;
    localparam int HZ_W       = 27;
    localparam int FACTOR_W   = 5;
    localparam int SHIFT_W    = 4;
    localparam int RPM_W      = 12;
    localparam int MOVE_W     = 24;
    localparam int OPCODE_W   = 2;
    localparam int STATUS_W   = 3;
    localparam int PHASE_W    = 2;
    localparam int OUT_PER_W  = 32;
    localparam int PULSE_W    = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 27;
    localparam int RATE_W     = RPM_W + MS_W;
    // Twice the largest step rate fits in this many bits.
    localparam int SPS_DEN_W  = 25;
    localparam int SECONDS_PER_MIN = 60;

    // The step rate is the rate product over sixty, taken as a multiplication by a rounded-up
    // reciprocal of sixty and a shift. It is exact for every product below 2**RATE_W.
    localparam int SPS_W       = 23;
    localparam int SPS_RECIP_W = 29;
    localparam int SPS_PROD_W  = RATE_W + SPS_RECIP_W;
    localparam int SPS_SHIFT   = 34;
    localparam logic [SPS_RECIP_W-1:0] SPS_RECIP = 29'd286331154;

    localparam logic [MS_W-1:0]     MS_RST     = 16'd1600;
    localparam logic [HZ_W-1:0]     HZ_RST     = 27'd1000000;
    localparam logic [FACTOR_W-1:0] FACTOR_RST = 5'd4;
    localparam logic [SHIFT_W-1:0]  SHIFT_RST  = 4'd5;
    localparam int FAST_RST = 1000;
    localparam int SLOW_RST = 10000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MICROSTEPS  = 2'd0,
        CFG_TIMER_HZ    = 2'd1,
        CFG_SLOW_FACTOR = 2'd2,
        CFG_RAMP_SHIFT  = 2'd3
    } cfg_idx_t;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK      = 2'd0,
        OP_START     = 2'd1,
        OP_SOFT_STOP = 2'd2,
        OP_HARD_STOP = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPTED = 3'd0,
        ST_IGNORED  = 3'd1,
        ST_BUSY     = 3'd2,
        ST_BAD_RPM  = 3'd3,
        ST_DONE     = 3'd4,
        ST_RUNNING  = 3'd5
    } status_t;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE   = 2'd0,
        PH_ACCEL  = 2'd1,
        PH_CRUISE = 2'd2,
        PH_DECEL  = 2'd3
    } phase_t;

    // Source of the period carried by a result word.
    typedef enum logic [2:0] {
        PS_ZERO  = 3'd0,
        PS_FAST  = 3'd1,
        PS_SLOW  = 3'd2,
        PS_ACCEL = 3'd3,
        PS_DECEL = 3'd4
    } psel_t;

    typedef enum logic [1:0] {
        DIV_FAST   = 2'd0,
        DIV_INTERP = 2'd1
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     mul_rate;
        logic     mul_sps;
        logic     div_go;
        div_sel_t div_sel;
        logic     take_fast;
        logic     commit_start;
        logic     soft_stop;
        logic     hard_stop;
        logic     tick_count;
        logic     tick_eval;
        logic     mul_interp;
        logic     result;
        status_t  res_status;
        psel_t    res_sel;
    } dp_cmd_t;

    typedef struct packed {
        opcode_t opcode;
        logic    running;
        logic    div_done;
        logic    quo_zero;
        logic    sps_zero;
        logic    tick_done;
        psel_t   tick_sel;
    } dp_stat_t;

endpackage

>>> rtl/stp_if.sv
`timescale 1ns / 1ps
interface stp_req_if import stp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [MOVE_W-1:0]   move_steps;
    logic [RPM_W-1:0]    speed_rpm;
    logic                dir_in;

    modport source (output valid, opcode, move_steps, speed_rpm, dir_in, input ready);
    modport sink (input valid, opcode, move_steps, speed_rpm, dir_in, output ready);
endinterface

interface stp_rsp_if import stp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [OUT_PER_W-1:0] half_period;
    logic [PULSE_W-1:0]   pulse_compare;
    logic                 moving;
    logic                 dir_out;
    logic [PHASE_W-1:0]   phase;

    modport source (output valid, status, half_period, pulse_compare, moving, dir_out, phase,
                    input ready);
    modport sink (input valid, status, half_period, pulse_compare, moving, dir_out, phase,
                  output ready);
endinterface

interface stp_cfg_if import stp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/stp_div.sv
`timescale 1ns / 1ps
module stp_div import stp_pkg::*; #(
    parameter int NW = 56,
    parameter int DW = 25
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);

    localparam int CNT_W = $clog2(NW + 1);

    logic [NW-1:0]    quo_reg;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DW:0]      rem_sh;
    logic             fits;

    // Restoring division, one quotient bit per cycle.
    assign rem_sh = {rem_reg, quo_reg[NW-1]};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NW-2:0], fits};
            rem_reg <= fits ? DW'(rem_sh - {1'b0, den_reg}) : rem_sh[DW-1:0];
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

>>> rtl/stp_datapath.sv
`timescale 1ns / 1ps
module stp_datapath import stp_pkg::*; #(
    parameter int STEP_BITS   = 24,
    parameter int PERIOD_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    input  logic [OPCODE_W-1:0]   opcode,
    input  logic [MOVE_W-1:0]     move_steps,
    input  logic [RPM_W-1:0]      speed_rpm,
    input  logic                  dir_in,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic [STATUS_W-1:0]   status,
    output logic [OUT_PER_W-1:0]  half_period,
    output logic [PULSE_W-1:0]    pulse_compare,
    output logic                  moving,
    output logic                  dir_out,
    output logic [PHASE_W-1:0]    phase
);

    localparam int HW  = STEP_BITS + 1;
    localparam int NW  = (PERIOD_BITS + STEP_BITS > RATE_W) ? PERIOD_BITS + STEP_BITS : RATE_W;
    localparam int DW  = (HW > SPS_DEN_W) ? HW : SPS_DEN_W;
    localparam int SPW = PERIOD_BITS + FACTOR_W;
    localparam logic [PERIOD_BITS-1:0] PMAX = '1;

    logic [MS_W-1:0]        ms_reg;
    logic [HZ_W-1:0]        hz_reg;
    logic [FACTOR_W-1:0]    factor_reg;
    logic [SHIFT_W-1:0]     shift_reg;

    opcode_t                op_reg;
    logic [STEP_BITS-1:0]   steps_reg;
    logic [RPM_W-1:0]       rpm_reg;
    logic                   dirin_reg;

    phase_t                 phase_reg;
    logic [HW-1:0]          hc_reg;
    logic [HW-1:0]          total_reg;
    logic [STEP_BITS-1:0]   accel_reg;
    logic [STEP_BITS-1:0]   cruise_reg;
    logic [HW-1:0]          decel_reg;
    logic [STEP_BITS-1:0]   origin_reg;
    logic [PERIOD_BITS-1:0] fast_reg;
    logic [PERIOD_BITS-1:0] slow_reg;
    logic                   run_reg;
    logic                   soft_reg;
    logic                   dir_reg;

    logic [NW-1:0]          prod_reg;
    logic [SPS_W-1:0]       sps_reg;
    logic [PERIOD_BITS-1:0] fastc_reg;
    logic [SPW-1:0]         slowprod_reg;
    logic [STEP_BITS-1:0]   ni_reg;
    logic [HW-1:0]          den_reg;

    status_t                status_reg;
    logic [PERIOD_BITS-1:0] period_reg;
    logic [PERIOD_BITS-2:0] pulse_reg;
    logic                   moving_reg;
    logic                   dirout_reg;
    phase_t                 phaseout_reg;

    logic [NW-1:0]          div_num;
    logic [DW-1:0]          div_den;
    logic                   div_done;
    logic [NW-1:0]          quo;

    logic [SPS_PROD_W-1:0]  sps_prod;
    logic [STEP_BITS-1:0]   n_w;
    logic [STEP_BITS-1:0]   k_w;
    logic [HW-1:0]          ac_sum;
    psel_t                  tick_sel;
    phase_t                 tick_phase;
    logic [PERIOD_BITS-1:0] diff;
    logic [PERIOD_BITS-1:0] fast_sat;
    logic [PERIOD_BITS-1:0] slow_sat;
    logic [FACTOR_W-1:0]    factor_eff;
    logic [STEP_BITS-1:0]   ramp;
    logic [HW-1:0]          two_ramp;
    logic [STEP_BITS-1:0]   cruise_new;
    logic [HW-1:0]          hc_inc;
    logic [STEP_BITS-1:0]   n1;
    logic [STEP_BITS-1:0]   all_w;
    logic [PERIOD_BITS-1:0] period_w;
    logic [PERIOD_BITS-1:0] period_m1;

    stp_div #(.NW(NW), .DW(DW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_go),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (quo)
    );

    always_comb
    begin
        case (cmd.div_sel)
            DIV_FAST:
            begin
                div_num = NW'(hz_reg);
                div_den = DW'({sps_reg, 1'b0});
            end
            default:
            begin
                div_num = prod_reg;
                div_den = DW'(den_reg);
            end
        endcase
    end

    assign sps_prod = SPS_PROD_W'(prod_reg[RATE_W-1:0]) * SPS_PROD_W'(SPS_RECIP);

    // Profile position of the current half step, in full steps.
    assign n_w    = hc_reg[HW-1:1];
    assign k_w    = n_w - origin_reg;
    assign ac_sum = {1'b0, accel_reg} + {1'b0, cruise_reg};

    always_comb
    begin
        if (n_w < accel_reg)
        begin
            tick_phase = PH_ACCEL;
            tick_sel   = PS_ACCEL;
        end
        else if ({1'b0, n_w} < ac_sum)
        begin
            tick_phase = PH_CRUISE;
            tick_sel   = PS_FAST;
        end
        else
        begin
            tick_phase = PH_DECEL;
            if (n_w < origin_reg)
                tick_sel = PS_FAST;
            else if (decel_reg == '0 || {1'b0, k_w} >= decel_reg)
                tick_sel = PS_SLOW;
            else
                tick_sel = PS_DECEL;
        end
    end

    assign diff       = slow_reg - fast_reg;
    assign fast_sat   = (quo > NW'(PMAX)) ? PMAX : quo[PERIOD_BITS-1:0];
    assign slow_sat   = (slowprod_reg > SPW'(PMAX)) ? PMAX : slowprod_reg[PERIOD_BITS-1:0];
    assign factor_eff = (factor_reg == '0) ? FACTOR_W'(1) : factor_reg;
    assign ramp       = steps_reg >> shift_reg;
    assign two_ramp   = {ramp, 1'b0};
    assign cruise_new = (two_ramp > {1'b0, steps_reg}) ? '0 : steps_reg - two_ramp[STEP_BITS-1:0];
    assign hc_inc     = hc_reg + 1'b1;
    assign n1         = hc_inc[HW-1:1];
    assign all_w      = total_reg[HW-1:1];

    always_comb
    begin
        case (cmd.res_sel)
            PS_FAST:  period_w = fast_reg;
            PS_SLOW:  period_w = slow_reg;
            PS_ACCEL: period_w = slow_reg - quo[PERIOD_BITS-1:0];
            PS_DECEL: period_w = fast_reg + quo[PERIOD_BITS-1:0];
            default:  period_w = '0;
        endcase
    end

    assign period_m1 = period_w - 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_reg     <= MS_RST;
            hz_reg     <= HZ_RST;
            factor_reg <= FACTOR_RST;
            shift_reg  <= SHIFT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_MICROSTEPS:  ms_reg     <= cfg_data[MS_W-1:0];
                CFG_TIMER_HZ:    hz_reg     <= cfg_data[HZ_W-1:0];
                CFG_SLOW_FACTOR: factor_reg <= cfg_data[FACTOR_W-1:0];
                CFG_RAMP_SHIFT:  shift_reg  <= cfg_data[SHIFT_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            hc_reg     <= '0;
            total_reg  <= '0;
            accel_reg  <= '0;
            cruise_reg <= '0;
            decel_reg  <= '0;
            origin_reg <= '0;
            fast_reg   <= PERIOD_BITS'(FAST_RST);
            slow_reg   <= PERIOD_BITS'(SLOW_RST);
            run_reg    <= 1'b0;
            soft_reg   <= 1'b0;
            dir_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.commit_start)
            begin
                fast_reg   <= fastc_reg;
                slow_reg   <= slow_sat;
                accel_reg  <= ramp;
                decel_reg  <= HW'(ramp);
                cruise_reg <= cruise_new;
                origin_reg <= ramp + cruise_new;
                total_reg  <= {steps_reg, 1'b0};
                hc_reg     <= '0;
                phase_reg  <= PH_ACCEL;
                dir_reg    <= dirin_reg;
                soft_reg   <= 1'b0;
                run_reg    <= 1'b1;
            end
            if (cmd.soft_stop)
                soft_reg <= 1'b1;
            if (cmd.hard_stop)
            begin
                run_reg   <= 1'b0;
                soft_reg  <= 1'b0;
                phase_reg <= PH_IDLE;
            end
            if (cmd.tick_count)
            begin
                hc_reg <= hc_inc;
                // A pending soft stop turns the rest of the move into one ramp down.
                if (soft_reg && phase_reg != PH_DECEL)
                begin
                    phase_reg  <= PH_DECEL;
                    origin_reg <= n1;
                    decel_reg  <= (all_w > n1) ? HW'(all_w - n1) : '0;
                    accel_reg  <= '0;
                    cruise_reg <= '0;
                end
            end
            if (cmd.tick_eval)
            begin
                if (hc_reg >= total_reg)
                begin
                    run_reg   <= 1'b0;
                    soft_reg  <= 1'b0;
                    phase_reg <= PH_IDLE;
                end
                else
                    phase_reg <= tick_phase;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= opcode_t'(opcode);
            steps_reg <= STEP_BITS'(move_steps);
            rpm_reg   <= speed_rpm;
            dirin_reg <= dir_in;
        end
        if (cmd.mul_rate)
            prod_reg <= NW'(rpm_reg) * NW'(ms_reg);
        if (cmd.mul_interp)
            prod_reg <= NW'(diff) * NW'(ni_reg);
        if (cmd.mul_sps)
            sps_reg <= sps_prod[SPS_SHIFT +: SPS_W];
        if (cmd.take_fast)
        begin
            fastc_reg    <= fast_sat;
            slowprod_reg <= SPW'(fast_sat) * SPW'(factor_eff);
        end
        if (cmd.tick_eval)
        begin
            ni_reg  <= (tick_sel == PS_ACCEL) ? n_w : k_w;
            den_reg <= (tick_sel == PS_ACCEL) ? HW'(accel_reg) : decel_reg;
        end
        if (cmd.result)
        begin
            status_reg   <= cmd.res_status;
            period_reg   <= period_w;
            pulse_reg    <= (period_w != '0) ? period_m1[PERIOD_BITS-1:1] : '0;
            moving_reg   <= run_reg;
            dirout_reg   <= dir_reg;
            phaseout_reg <= phase_reg;
        end
    end

    assign stat.opcode    = op_reg;
    assign stat.running   = run_reg;
    assign stat.div_done  = div_done;
    assign stat.quo_zero  = (quo == '0);
    assign stat.sps_zero  = (sps_reg == '0);
    assign stat.tick_done = (hc_reg >= total_reg);
    assign stat.tick_sel  = tick_sel;

    assign status        = status_reg;
    assign half_period   = OUT_PER_W'(period_reg);
    assign pulse_compare = PULSE_W'(pulse_reg);
    assign moving        = moving_reg;
    assign dir_out       = dirout_reg;
    assign phase         = phaseout_reg;

endmodule

>>> rtl/stp_ctrl.sv
`timescale 1ns / 1ps
module stp_ctrl import stp_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SPS_MUL,
        S_SPS_CHK,
        S_FAST_WAIT,
        S_COMMIT,
        S_TICK,
        S_INT_MUL,
        S_INT_DIV,
        S_INT_WAIT,
        S_RES,
        S_OUT
    } state_t;

    state_t  state_reg;
    state_t  state_next;
    status_t status_reg;
    status_t status_next;
    psel_t   sel_reg;
    psel_t   sel_next;

    always_comb
    begin
        cmd         = '0;
        state_next  = state_reg;
        status_next = status_reg;
        sel_next    = sel_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                sel_next    = PS_ZERO;
                status_next = ST_IGNORED;
                state_next  = S_RES;
                case (stat.opcode)
                    OP_START:
                    begin
                        if (stat.running)
                            status_next = ST_BUSY;
                        else
                        begin
                            cmd.mul_rate = 1'b1;
                            state_next   = S_SPS_MUL;
                        end
                    end
                    OP_SOFT_STOP:
                    begin
                        if (stat.running)
                        begin
                            cmd.soft_stop = 1'b1;
                            status_next   = ST_ACCEPTED;
                        end
                    end
                    OP_HARD_STOP:
                    begin
                        if (stat.running)
                        begin
                            cmd.hard_stop = 1'b1;
                            status_next   = ST_ACCEPTED;
                        end
                    end
                    default:
                    begin
                        if (stat.running)
                        begin
                            cmd.tick_count = 1'b1;
                            state_next     = S_TICK;
                        end
                    end
                endcase
            end
            S_SPS_MUL:
            begin
                cmd.mul_sps = 1'b1;
                state_next  = S_SPS_CHK;
            end
            S_SPS_CHK:
            begin
                if (stat.sps_zero)
                begin
                    status_next = ST_BAD_RPM;
                    state_next  = S_RES;
                end
                else
                begin
                    cmd.div_go  = 1'b1;
                    cmd.div_sel = DIV_FAST;
                    state_next  = S_FAST_WAIT;
                end
            end
            S_FAST_WAIT:
            begin
                if (stat.div_done)
                begin
                    if (stat.quo_zero)
                    begin
                        status_next = ST_BAD_RPM;
                        state_next  = S_RES;
                    end
                    else
                    begin
                        cmd.take_fast = 1'b1;
                        state_next    = S_COMMIT;
                    end
                end
            end
            S_COMMIT:
            begin
                cmd.commit_start = 1'b1;
                status_next      = ST_ACCEPTED;
                sel_next         = PS_SLOW;
                state_next       = S_RES;
            end
            S_TICK:
            begin
                cmd.tick_eval = 1'b1;
                if (stat.tick_done)
                begin
                    status_next = ST_DONE;
                    sel_next    = PS_ZERO;
                    state_next  = S_RES;
                end
                else
                begin
                    status_next = ST_RUNNING;
                    sel_next    = stat.tick_sel;
                    if (stat.tick_sel == PS_ACCEL || stat.tick_sel == PS_DECEL)
                        state_next = S_INT_MUL;
                    else
                        state_next = S_RES;
                end
            end
            S_INT_MUL:
            begin
                cmd.mul_interp = 1'b1;
                state_next     = S_INT_DIV;
            end
            S_INT_DIV:
            begin
                cmd.div_go  = 1'b1;
                cmd.div_sel = DIV_INTERP;
                state_next  = S_INT_WAIT;
            end
            S_INT_WAIT:
            begin
                if (stat.div_done)
                    state_next = S_RES;
            end
            S_RES:
            begin
                cmd.result     = 1'b1;
                cmd.res_status = status_reg;
                cmd.res_sel    = sel_reg;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (rsp_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= ST_IGNORED;
            sel_reg    <= PS_ZERO;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
            sel_reg    <= sel_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = (state_reg == S_OUT);

endmodule

>>> rtl/stepper_trapezoid_profile_core.sv
`timescale 1ns / 1ps
// Trapezoidal ramp generator for a stepper drive. Each request word is a tick (one half step),
// a start, a soft stop or a hard stop, and each gives exactly one response word carrying the
// status, the period for the next half step and the matching half-period compare value. One
// word is handled at a time. A tick on a ramp and an accepted start use the radix-2 divider,
// which yields one quotient bit per cycle over a dividend of max(PERIOD_BITS + STEP_BITS, 28)
// bits (56 with the default parameters), the start dividing once for the cruise period after a
// reciprocal multiplication has given the step rate. A tick that needs no interpolation (cruise,
// past the ramp, or the end of the move), a stop, a start while busy, a tick or stop while idle
// and a start refused for a zero step rate do not use the divider; a start refused for a zero
// cruise period is refused once the division is through. A response waits in its output
// register until it is taken, and the next request word can be accepted in the cycle after
// that. Configuration writes are always taken and should be made only while no move word is
// in flight.
module stepper_trapezoid_profile_core import stp_pkg::*; #(
    parameter int STEP_BITS   = 24,
    parameter int PERIOD_BITS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    stp_req_if.sink   req,
    stp_rsp_if.source rsp,
    stp_cfg_if.sink   cfg
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg.ready = 1'b1;

    stp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    stp_datapath #(
        .STEP_BITS   (STEP_BITS),
        .PERIOD_BITS (PERIOD_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .opcode        (req.opcode),
        .move_steps    (req.move_steps),
        .speed_rpm     (req.speed_rpm),
        .dir_in        (req.dir_in),
        .cfg_we        (cfg.valid),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .status        (rsp.status),
        .half_period   (rsp.half_period),
        .pulse_compare (rsp.pulse_compare),
        .moving        (rsp.moving),
        .dir_out       (rsp.dir_out),
        .phase         (rsp.phase)
    );

endmodule

>>> rtl/stp_checker.sv
`timescale 1ns / 1ps
`include "stepper_trapezoid_profile_core_assert.svh"
module stp_checker import stp_pkg::*; (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 rsp_valid,
    input logic                 rsp_ready,
    input logic [STATUS_W-1:0]  status,
    input logic [OUT_PER_W-1:0] half_period,
    input logic                 moving,
    input logic [PHASE_W-1:0]   phase
);

    logic stalled;
    logic no_period_word;

    assign stalled        = rsp_valid && !rsp_ready;
    assign no_period_word = rsp_valid && (status == ST_IGNORED || status == ST_BUSY ||
                                          status == ST_BAD_RPM || status == ST_DONE);

    // A stalled response word keeps its contents.
    `STP_ASSERT_NEXT(a_rsp_hold, clk, rst_n, stalled, rsp_valid && $stable({status, half_period}), "stalled word changed")

    // When no move is running the phase reads idle.
    `STP_ASSERT_SAME(a_idle_phase, clk, rst_n, rsp_valid && !moving, phase == PH_IDLE, "phase not idle while stopped")

    // The end of a move always drops the moving flag.
    `STP_ASSERT_SAME(a_done_stops, clk, rst_n, rsp_valid && status == ST_DONE, !moving, "move done but still moving")

    // Refusals and the end of a move carry no period.
    `STP_ASSERT_SAME(a_no_period, clk, rst_n, no_period_word, half_period == '0, "period given without a running move")

endmodule

bind stepper_trapezoid_profile_core stp_checker u_stp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .status      (rsp.status),
    .half_period (rsp.half_period),
    .moving      (rsp.moving),
    .phase       (rsp.phase)
);

>>> tb/tb_stepper_trapezoid_profile_core.sv
`timescale 1ns / 1ps
module tb_stepper_trapezoid_profile_core;
    import stp_pkg::*;

    localparam int STALL_LIMIT = 5000;

    typedef struct {
        status_t      status;
        logic [31:0]  half_period;
        logic [30:0]  pulse_compare;
        logic         moving;
        logic         dir_out;
        phase_t       phase;
    } motion_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    stp_req_if req ();
    stp_rsp_if rsp ();
    stp_cfg_if cfg ();

    stepper_trapezoid_profile_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Shadow of the registers and of the motion state.
    longint unsigned sh_ms, sh_hz, sh_factor, sh_shift;
    longint unsigned half_cnt, half_total, accel_n, cruise_n, decel_n, decel_at;
    longint unsigned fast_per, slow_per;
    phase_t          cur_phase;
    bit              is_running, soft_pending, dir_level;

    motion_word_t expected_words[$];
    int  error_count = 0;
    bit  no_gaps = 0;
    int  words_sent = 0;
    int  idle_cycles = 0;
    int  rsp_stall = 0;

    function automatic longint unsigned ramp_period(longint unsigned n);
        longint unsigned diff;
        diff = slow_per - fast_per;
        if (n < accel_n)
        begin
            cur_phase = PH_ACCEL;
            return slow_per - (diff * n) / accel_n;
        end
        if (n < accel_n + cruise_n)
        begin
            cur_phase = PH_CRUISE;
            return fast_per;
        end
        cur_phase = PH_DECEL;
        if (n < decel_at)
            return fast_per;
        n = n - decel_at;
        if (decel_n == 0 || n >= decel_n)
            return slow_per;
        return fast_per + (diff * n) / decel_n;
    endfunction

    function automatic motion_word_t predict_motion(opcode_t op, logic [23:0] steps,
                                                    logic [11:0] rpm, logic dir);
        motion_word_t w;
        longint unsigned per, sps, fast, fac, ramp, n, all;
        w.status = ST_IGNORED;
        per = 0;
        case (op)
            OP_START:
            begin
                if (is_running)
                    w.status = ST_BUSY;
                else
                begin
                    sps = (longint'(rpm) * sh_ms) / SECONDS_PER_MIN;
                    fast = (sps != 0) ? sh_hz / (sps * 2) : 0;
                    if (fast == 0)
                        w.status = ST_BAD_RPM;
                    else
                    begin
                        fac = (sh_factor != 0) ? sh_factor : 1;
                        ramp = longint'(steps) >> sh_shift;
                        fast_per = (fast > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : fast;
                        slow_per = fast_per * fac;
                        if (slow_per > 64'hFFFF_FFFF)
                            slow_per = 64'hFFFF_FFFF;
                        accel_n = ramp;
                        decel_n = ramp;
                        cruise_n = (2 * ramp > steps) ? 0 : steps - 2 * ramp;
                        decel_at = accel_n + cruise_n;
                        half_total = (longint'(steps) * 2) & 64'h1FF_FFFF;
                        half_cnt = 0;
                        cur_phase = PH_ACCEL;
                        dir_level = dir;
                        soft_pending = 0;
                        is_running = 1;
                        w.status = ST_ACCEPTED;
                        per = slow_per;
                    end
                end
            end
            OP_SOFT_STOP:
            begin
                if (is_running)
                begin
                    soft_pending = 1;
                    w.status = ST_ACCEPTED;
                end
            end
            OP_HARD_STOP:
            begin
                if (is_running)
                begin
                    is_running = 0;
                    soft_pending = 0;
                    cur_phase = PH_IDLE;
                    w.status = ST_ACCEPTED;
                end
            end
            default:
            begin
                if (is_running)
                begin
                    half_cnt = (half_cnt + 1) & 64'h1FF_FFFF;
                    if (soft_pending && cur_phase != PH_DECEL)
                    begin
                        n = half_cnt >> 1;
                        all = half_total >> 1;
                        cur_phase = PH_DECEL;
                        decel_at = n;
                        decel_n = (all > n) ? all - n : 0;
                        accel_n = 0;
                        cruise_n = 0;
                    end
                    if (half_cnt >= half_total)
                    begin
                        is_running = 0;
                        soft_pending = 0;
                        cur_phase = PH_IDLE;
                        w.status = ST_DONE;
                    end
                    else
                    begin
                        per = ramp_period(half_cnt >> 1);
                        w.status = ST_RUNNING;
                    end
                end
            end
        endcase
        w.half_period = per[31:0];
        w.pulse_compare = (per != 0) ? 31'((per - 1) / 2) : '0;
        w.moving = is_running;
        w.dir_out = dir_level;
        w.phase = cur_phase;
        return w;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Sends one request word and records the expected response once it is taken.
    task automatic send_word(opcode_t op, logic [23:0] steps, logic [11:0] rpm, logic dir);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.opcode <= op;
        req.move_steps <= steps;
        req.speed_rpm <= rpm;
        req.dir_in <= dir;
        do
            @(posedge clk);
        while (!req.ready);
        expected_words.push_back(predict_motion(op, steps, rpm, dir));
        words_sent++;
    endtask

    task automatic send_noise();
        send_word(opcode_t'($urandom_range(0, 3)), 24'($urandom), 12'($urandom), 1'($urandom));
    endtask

    // Lets every outstanding word come back, then a margin for the datapath to fall quiet.
    task automatic drain();
        req.valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (130) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [26:0] value);
        drain();
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        case (idx)
            CFG_MICROSTEPS:  sh_ms = value[15:0];
            CFG_TIMER_HZ:    sh_hz = value;
            CFG_SLOW_FACTOR: sh_factor = value[4:0];
            default:         sh_shift = value[3:0];
        endcase
    endtask

    // Runs a move to its end with the odd stop or stray word thrown in.
    task automatic run_move(logic [23:0] steps, logic [11:0] rpm, logic dir, int disturb);
        int guard;
        send_word(OP_START, steps, rpm, dir);
        guard = 0;
        while (is_running && guard < 200)
        begin
            if (disturb > 0 && $urandom_range(0, 99) < disturb)
            begin
                case ($urandom_range(0, 3))
                    0: send_word(OP_SOFT_STOP, 24'($urandom), 12'($urandom), 1'($urandom));
                    1: send_word(OP_HARD_STOP, 24'($urandom), 12'($urandom), 1'($urandom));
                    2: send_word(OP_START, 24'($urandom), 12'($urandom), 1'($urandom));
                    default: send_noise();
                endcase
            end
            else
                send_word(OP_TICK, 24'($urandom), 12'($urandom), 1'($urandom));
            guard++;
        end
        if (is_running)
            send_word(OP_HARD_STOP, '0, '0, 1'b0);
    endtask

    task automatic test_idle_requests();
        send_word(OP_TICK, '0, '0, 1'b0);
        send_word(OP_SOFT_STOP, 24'hFFFFFF, 12'hFFF, 1'b1);
        send_word(OP_HARD_STOP, '0, '0, 1'b0);
        send_word(OP_START, 24'd10, 12'd0, 1'b1);
        send_word(OP_START, 24'd0, 12'd60, 1'b1);
        send_word(OP_TICK, '0, '0, 1'b0);
    endtask

    task automatic test_full_range_move();
        send_word(OP_START, 24'hFFFFFF, 12'hFFF, 1'b1);
        repeat (3) send_word(OP_TICK, '0, '0, 1'b0);
        send_word(OP_START, 24'h000001, 12'h001, 1'b0);
        send_word(OP_SOFT_STOP, '0, '0, 1'b0);
        repeat (2) send_word(OP_TICK, '0, '0, 1'b0);
        send_word(OP_HARD_STOP, '0, '0, 1'b0);
        send_word(OP_TICK, '0, '0, 1'b0);
    endtask

    task automatic test_ramp_shapes();
        write_reg(CFG_RAMP_SHIFT, 27'd0);
        run_move(24'd4, 12'd100, 1'b1, 0);
        write_reg(CFG_RAMP_SHIFT, 27'd1);
        write_reg(CFG_SLOW_FACTOR, 27'd0);
        run_move(24'd5, 12'd300, 1'b0, 0);
        write_reg(CFG_SLOW_FACTOR, 27'd31);
        run_move(24'd6, 12'd20, 1'b1, 0);
    endtask

    task automatic test_register_extremes();
        write_reg(CFG_MICROSTEPS, 27'd1);
        write_reg(CFG_TIMER_HZ, 27'd1);
        send_word(OP_START, 24'd3, 12'hFFF, 1'b1);
        write_reg(CFG_TIMER_HZ, 27'd100000000);
        run_move(24'd3, 12'd59, 1'b1, 0);
        run_move(24'd3, 12'd60, 1'b1, 0);
        write_reg(CFG_MICROSTEPS, 27'd65535);
        write_reg(CFG_RAMP_SHIFT, 27'd15);
        run_move(24'd4, 12'hFFF, 1'b0, 0);
        write_reg(CFG_TIMER_HZ, 27'h7FFFFFF);
        write_reg(CFG_SLOW_FACTOR, 27'd16);
        write_reg(CFG_RAMP_SHIFT, 27'd10);
        run_move(24'd2048, 12'd1, 1'b1, 0);
    endtask

    task automatic test_random_moves();
        logic [23:0] steps;
        int r;
        while (words_sent < 850)
        begin
            r = $urandom_range(0, 99);
            if (r < 12)
            begin
                case ($urandom_range(0, 3))
                    0: write_reg(CFG_MICROSTEPS, 27'($urandom_range(1, 65535)));
                    1: write_reg(CFG_TIMER_HZ, ($urandom_range(0, 3) == 0) ?
                                 27'($urandom_range(1, 5000)) : 27'($urandom_range(1, 100000000)));
                    2: write_reg(CFG_SLOW_FACTOR, 27'($urandom_range(0, 31)));
                    default: write_reg(CFG_RAMP_SHIFT, 27'($urandom_range(0, 4)));
                endcase
            end
            if (r >= 90)
                no_gaps = ~no_gaps;
            if ($urandom_range(0, 19) == 0)
            begin
                send_noise();
                continue;
            end
            steps = ($urandom_range(0, 9) == 0) ? 24'($urandom_range(0, 60)) :
                    24'($urandom_range(0, 16));
            run_move(steps, 12'($urandom_range(0, 4095)), 1'($urandom),
                     ($urandom_range(0, 2) == 0) ? 8 : 0);
        end
        no_gaps = 0;
    endtask

    task automatic test_hold_until_drained();
        send_word(OP_START, 24'd6, 12'd500, 1'b1);
        drain();
        run_move(24'd5, 12'd700, 1'b0, 20);
    endtask

    // Response side: random back-pressure and the field-by-field comparison.
    always @(posedge clk)
    begin
        motion_word_t w;
        if (rsp.valid && rsp.ready && rst_n)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected response word, status %0d", rsp.status);
                error_count++;
            end
            else
            begin
                w = expected_words.pop_front();
                if (rsp.status !== w.status)
                begin
                    $error("status: expected %0d, got %0d", w.status, rsp.status);
                    error_count++;
                end
                if (rsp.half_period !== w.half_period)
                begin
                    $error("half_period: expected %0d, got %0d", w.half_period, rsp.half_period);
                    error_count++;
                end
                if (rsp.pulse_compare !== w.pulse_compare)
                begin
                    $error("pulse_compare: expected %0d, got %0d", w.pulse_compare,
                           rsp.pulse_compare);
                    error_count++;
                end
                if (rsp.moving !== w.moving)
                begin
                    $error("moving: expected %0d, got %0d", w.moving, rsp.moving);
                    error_count++;
                end
                if (rsp.dir_out !== w.dir_out)
                begin
                    $error("dir_out: expected %0d, got %0d", w.dir_out, rsp.dir_out);
                    error_count++;
                end
                if (rsp.phase !== w.phase)
                begin
                    $error("phase: expected %0d, got %0d", w.phase, rsp.phase);
                    error_count++;
                end
            end
        end
        if (rsp_stall > 0)
        begin
            rsp_stall--;
            rsp.ready <= 1'b0;
        end
        else if (no_gaps || $urandom_range(0, 99) < 60)
            rsp.ready <= 1'b1;
        else
        begin
            rsp.ready <= 1'b0;
            rsp_stall = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 80) :
                        $urandom_range(0, 3);
        end
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        req.valid = 1'b0;
        req.opcode = OP_TICK;
        req.move_steps = '0;
        req.speed_rpm = '0;
        req.dir_in = 1'b0;
        rsp.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = CFG_MICROSTEPS;
        cfg.data = '0;
        sh_ms = MS_RST;
        sh_hz = HZ_RST;
        sh_factor = FACTOR_RST;
        sh_shift = SHIFT_RST;
        cur_phase = PH_IDLE;
        half_cnt = 0;
        half_total = 0;
        accel_n = 0;
        cruise_n = 0;
        decel_n = 0;
        decel_at = 0;
        fast_per = FAST_RST;
        slow_per = SLOW_RST;
        is_running = 0;
        soft_pending = 0;
        dir_level = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_requests();
        test_full_range_move();
        test_ramp_shapes();
        test_register_extremes();
        test_hold_until_drained();
        test_random_moves();

        drain();
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
